/* rtl/rrct_pkg.sv */
package rrct_pkg;

   localparam int PROCESS_SLOTS = 16;
   localparam int BURST_BITS    = 16;

   // fixed field widths
   localparam int QUANTUM_BITS = 16;
   localparam int INPUT_BITS   = 16;
   localparam int INDEX_BITS   = 4;
   localparam int TIME_BITS    = 20;
   localparam int SUM_W        = 24;

   localparam int IDX_W     = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
   localparam int COUNT_W   = $clog2(PROCESS_SLOTS + 1);
   localparam int ELAPSED_W = BURST_BITS + COUNT_W;
   localparam int CMP_W     = (BURST_BITS > QUANTUM_BITS) ? BURST_BITS : QUANTUM_BITS;

   localparam logic [QUANTUM_BITS-1:0] QUANTUM_RESET = QUANTUM_BITS'(4);

   // register indexes
   localparam logic REG_TIME_QUANTUM = 1'b0;

   typedef struct packed {
      logic                  valid;
      logic                  done;
      logic [IDX_W-1:0]      idx;
      logic [BURST_BITS-1:0] rem;
      logic [BURST_BITS-1:0] orig;
      logic [ELAPSED_W-1:0]  finish;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctl_type;

   typedef struct packed {
      entry_type            entry;
      logic [ELAPSED_W-1:0] elapsed;
      logic                 finished;
   } svc_out_type;

endpackage

/* rtl/rrct_if.sv */
interface rrct_req_if;
   logic                             valid;
   logic                             ready;
   logic [rrct_pkg::INPUT_BITS-1:0]  burst_time;
   logic                             is_last;

   modport source (output valid, output burst_time, output is_last, input ready);
   modport sink   (input valid, input burst_time, input is_last, output ready);
endinterface

interface rrct_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [rrct_pkg::INDEX_BITS-1:0] process_index;
   logic [rrct_pkg::TIME_BITS-1:0]  completion_time;
   logic [rrct_pkg::TIME_BITS-1:0]  turnaround_time;
   logic [rrct_pkg::TIME_BITS-1:0]  waiting_time;
   logic [rrct_pkg::SUM_W-1:0]      total_turnaround;
   logic [rrct_pkg::SUM_W-1:0]      total_waiting;
   logic                            last_result;

   modport source (output valid, output process_index, output completion_time,
                   output turnaround_time, output waiting_time, output total_turnaround,
                   output total_waiting, output last_result, input ready);
   modport sink   (input valid, input process_index, input completion_time,
                   input turnaround_time, input waiting_time, input total_turnaround,
                   input total_waiting, input last_result, output ready);
endinterface

/* rtl/rrct_cell.sv */
module rrct_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  rrct_pkg::cell_ctl_type ctl,
   input  rrct_pkg::entry_type    d,
   output rrct_pkg::entry_type    q
);

   logic                valid_ff;
   rrct_pkg::entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.clear) begin
         valid_ff <= 1'b0;
      end else if (ctl.shift) begin
         valid_ff <= d.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         entry_ff <= d;
      end
   end

   always_comb begin
      q       = entry_ff;
      q.valid = valid_ff;
   end

endmodule

/* rtl/rrct_service.sv */
module rrct_service (
   input  rrct_pkg::entry_type                      head,
   input  logic [rrct_pkg::QUANTUM_BITS-1:0]        quantum,
   input  logic [rrct_pkg::ELAPSED_W-1:0]           elapsed,
   output rrct_pkg::svc_out_type                    result
);

   logic [rrct_pkg::CMP_W-1:0]     rem_ext;
   logic [rrct_pkg::CMP_W-1:0]     q_ext;
   logic                           fits;
   logic [rrct_pkg::ELAPSED_W-1:0] end_time;

   assign rem_ext  = (rrct_pkg::CMP_W)'(head.rem);
   assign q_ext    = (rrct_pkg::CMP_W)'(quantum);
   assign fits     = (rem_ext <= q_ext);
   assign end_time = elapsed + (rrct_pkg::ELAPSED_W)'(head.rem);

   always_comb begin
      result.entry    = head;
      result.elapsed  = elapsed;
      result.finished = 1'b0;
      if (head.valid && !head.done) begin
         if (fits) begin
            result.entry.rem    = '0;
            result.entry.done   = 1'b1;
            result.entry.finish = end_time;
            result.elapsed      = end_time;
            result.finished     = 1'b1;
         end else begin
            // quantum < rem here, so it fits the burst width
            result.entry.rem = head.rem - (rrct_pkg::BURST_BITS)'(quantum);
            result.elapsed   = elapsed + (rrct_pkg::ELAPSED_W)'(quantum);
         end
      end
   end

endmodule

/* rtl/round_robin_completion_times_core.sv */
// Round-robin completion time engine. Bursts are loaded one beat per cycle into a
// ring of PROCESS_SLOTS cells (16); a beat with is_last set starts the run, and a
// set beyond 16 processes drops the extra bursts. During the run the ring rotates
// one cell per cycle past a single service stage at its head, so every cell passes
// the stage once per round-robin pass whatever the set size; a quantum of zero counts
// as one. Results then leave in load order, one beat per cycle while rsp is ready,
// once the ring has rotated the first index to the head; the last beat carries the
// totals and last_result. No new burst is accepted from the is_last beat until the
// last result has been registered. The quantum sits at byte address 0 of the APB
// port and must only be written while the block is idle.
module round_robin_completion_times_core (
   input  logic                                 clock,
   input  logic                                 reset,
   rrct_req_if.sink                             req_chan,
   rrct_rsp_if.source                           rsp_chan,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [2:0]                           paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);

   localparam int SLOTS = rrct_pkg::PROCESS_SLOTS;
   localparam int CW    = rrct_pkg::COUNT_W;
   localparam int EW    = rrct_pkg::ELAPSED_W;

   // sequencer states
   localparam logic [1:0] ST_LOAD = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0]                          state_ff, state_in;
   logic [CW-1:0]                       count_ff, count_in;   // loaded processes
   logic [CW-1:0]                       active_ff, active_in; // not yet finished
   logic [EW-1:0]                       elapsed_ff, elapsed_in;
   logic [rrct_pkg::IDX_W-1:0]          out_idx_ff, out_idx_in;
   logic [rrct_pkg::SUM_W-1:0]          sum_t_ff, sum_t_in;
   logic [rrct_pkg::SUM_W-1:0]          sum_w_ff, sum_w_in;
   logic [rrct_pkg::QUANTUM_BITS-1:0]   quantum_ff;
   logic [rrct_pkg::QUANTUM_BITS-1:0]   q_eff;

   // output register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [rrct_pkg::INDEX_BITS-1:0]     rsp_index_ff, rsp_index_in;
   logic [rrct_pkg::TIME_BITS-1:0]      rsp_compl_ff, rsp_compl_in;
   logic [rrct_pkg::TIME_BITS-1:0]      rsp_wait_ff, rsp_wait_in;
   logic [rrct_pkg::SUM_W-1:0]          rsp_tot_t_ff, rsp_tot_t_in;
   logic [rrct_pkg::SUM_W-1:0]          rsp_tot_w_ff, rsp_tot_w_in;
   logic                                rsp_last_ff, rsp_last_in;

   rrct_pkg::entry_type                 cell_q [SLOTS];
   rrct_pkg::entry_type                 tail_d;
   rrct_pkg::entry_type                 head;
   rrct_pkg::entry_type                 new_entry;
   rrct_pkg::cell_ctl_type              ctl;
   rrct_pkg::svc_out_type               svc;

   logic                                req_beat;
   logic                                can_emit;
   logic                                match;
   logic                                emit;
   logic                                final_beat;
   logic                                room;
   logic [EW-1:0]                       wait_full;
   logic [rrct_pkg::SUM_W-1:0]          sum_t_next, sum_w_next;

   // ---------------- configuration port ----------------
   assign pready = 1'b1;
   assign prdata = (paddr[2] == rrct_pkg::REG_TIME_QUANTUM) ? 32'(quantum_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= rrct_pkg::QUANTUM_RESET;
      end else if (psel && penable && pwrite && (paddr[2] == rrct_pkg::REG_TIME_QUANTUM)) begin
         quantum_ff <= pwdata[rrct_pkg::QUANTUM_BITS-1:0];
      end
   end

   assign q_eff = (quantum_ff == '0) ? rrct_pkg::QUANTUM_BITS'(1) : quantum_ff;

   // ---------------- cell ring ----------------
   // cell i takes cell i+1; the tail takes a new burst, the serviced head, or the head as it is
   genvar gi;
   generate
      for (gi = 0; gi < SLOTS; gi++) begin : g_cell
         if (gi == SLOTS - 1) begin : g_tail
            rrct_cell u_cell (
               .clock (clock),
               .reset (reset),
               .ctl   (ctl),
               .d     (tail_d),
               .q     (cell_q[gi])
            );
         end else begin : g_body
            rrct_cell u_cell (
               .clock (clock),
               .reset (reset),
               .ctl   (ctl),
               .d     (cell_q[gi+1]),
               .q     (cell_q[gi])
            );
         end
      end
   endgenerate

   assign head = cell_q[0];

   rrct_service u_service (
      .head    (head),
      .quantum (q_eff),
      .elapsed (elapsed_ff),
      .result  (svc)
   );

   // ---------------- control ----------------
   assign req_beat       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_LOAD);
   assign room           = (count_ff < CW'(SLOTS));

   always_comb begin
      new_entry        = '0;
      new_entry.valid  = 1'b1;
      new_entry.idx    = rrct_pkg::IDX_W'(count_ff);
      new_entry.rem    = rrct_pkg::BURST_BITS'(req_chan.burst_time);
      new_entry.orig   = rrct_pkg::BURST_BITS'(req_chan.burst_time);
   end

   // result of the head cell during output
   assign can_emit   = !rsp_valid_ff || rsp_chan.ready;
   assign match      = head.valid && (head.idx == out_idx_ff);
   assign emit       = (state_ff == ST_OUT) && match && can_emit;
   assign final_beat = (CW'(out_idx_ff) == count_ff - CW'(1));
   assign wait_full  = head.finish - EW'(head.orig);
   assign sum_t_next = sum_t_ff + rrct_pkg::SUM_W'(head.finish);
   assign sum_w_next = sum_w_ff + rrct_pkg::SUM_W'(wait_full);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      active_in  = active_ff;
      elapsed_in = elapsed_ff;
      out_idx_in = out_idx_ff;
      sum_t_in   = sum_t_ff;
      sum_w_in   = sum_w_ff;
      tail_d     = head;
      ctl        = '0;

      case (state_ff)
         ST_LOAD: begin
            if (req_beat) begin
               if (room) begin
                  tail_d    = new_entry;
                  ctl.shift = 1'b1;
                  count_in  = count_ff + CW'(1);
               end
               if (req_chan.is_last) begin
                  state_in   = ST_RUN;
                  active_in  = count_in;
                  elapsed_in = '0;
                  out_idx_in = '0;
                  sum_t_in   = '0;
                  sum_w_in   = '0;
               end
            end
         end
         ST_RUN: begin
            // one cell per cycle passes the service stage
            ctl.shift  = 1'b1;
            tail_d     = svc.entry;
            elapsed_in = svc.elapsed;
            if (svc.finished) begin
               active_in = active_ff - CW'(1);
               if (active_ff == CW'(1)) begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            // rotate until the next index in load order reaches the head
            if (!match) begin
               ctl.shift = 1'b1;
            end else if (can_emit) begin
               ctl.shift  = 1'b1;
               out_idx_in = out_idx_ff + rrct_pkg::IDX_W'(1);
               sum_t_in   = sum_t_next;
               sum_w_in   = sum_w_next;
               if (final_beat) begin
                  ctl.clear = 1'b1;
                  count_in  = '0;
                  state_in  = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_index_in = rsp_index_ff;
      rsp_compl_in = rsp_compl_ff;
      rsp_wait_in  = rsp_wait_ff;
      rsp_tot_t_in = rsp_tot_t_ff;
      rsp_tot_w_in = rsp_tot_w_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = rrct_pkg::INDEX_BITS'(head.idx);
         rsp_compl_in = rrct_pkg::TIME_BITS'(head.finish);
         rsp_wait_in  = rrct_pkg::TIME_BITS'(wait_full);
         rsp_tot_t_in = final_beat ? sum_t_next : '0;
         rsp_tot_w_in = final_beat ? sum_w_next : '0;
         rsp_last_in  = final_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      elapsed_ff   <= elapsed_in;
      out_idx_ff   <= out_idx_in;
      sum_t_ff     <= sum_t_in;
      sum_w_ff     <= sum_w_in;
      rsp_index_ff <= rsp_index_in;
      rsp_compl_ff <= rsp_compl_in;
      rsp_wait_ff  <= rsp_wait_in;
      rsp_tot_t_ff <= rsp_tot_t_in;
      rsp_tot_w_ff <= rsp_tot_w_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.process_index    = rsp_index_ff;
   assign rsp_chan.completion_time  = rsp_compl_ff;
   assign rsp_chan.turnaround_time  = rsp_compl_ff;
   assign rsp_chan.waiting_time     = rsp_wait_ff;
   assign rsp_chan.total_turnaround = rsp_tot_t_ff;
   assign rsp_chan.total_waiting    = rsp_tot_w_ff;
   assign rsp_chan.last_result      = rsp_last_ff;

   // ---------------- assertions ----------------
   a_active_le_count: assert property (@(posedge clock) disable iff (reset)
      active_ff <= count_ff)
      else $error("more active processes than loaded");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(SLOTS))
      else $error("load count beyond slot count");

   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (active_ff != '0))
      else $error("run with no active process");

   a_final_returns: assert property (@(posedge clock) disable iff (reset)
      (emit && final_beat) |=> (state_ff == ST_LOAD && count_ff == '0))
      else $error("final result did not return to load");

endmodule
